@@ rtl/core/onc_pkg.sv @@
// Shared types, constants and the divider step of the overbright color normalizer.
package onc_pkg;

  localparam int CHAN_W         = 8;
  localparam int SHIFT_W        = 3;
  localparam int NUM_COLORS     = 3;
  localparam int SHIFTED_W      = CHAN_W + (1 << SHIFT_W) - 1;
  localparam int NUM_W          = 2 * CHAN_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = CHAN_W / BITS_PER_STAGE;

  localparam logic [CHAN_W-1:0]  CHANNEL_MAX = {CHAN_W{1'b1}};
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(1);

  localparam int RED   = 0;
  localparam int GREEN = 1;
  localparam int BLUE  = 2;

  // Per-channel divider state: partial remainder, unused dividend bits, quotient so far.
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] low;
    logic [CHAN_W-1:0] quo;
  } chan_div_t;

  // One pixel as it travels down the divider pipeline.
  typedef struct packed {
    chan_div_t [NUM_COLORS-1:0]               ch;
    logic      [NUM_COLORS-1:0][CHAN_W-1:0]   plain;
    logic      [CHAN_W-1:0]                   divisor;
    logic                                     ovf;
    logic      [CHAN_W-1:0]                   alpha;
  } pix_t;

  // Advance the restoring division of all three channels by BITS_PER_STAGE bits.
  function automatic pix_t div_stage(input pix_t p);
    pix_t          o;
    logic [CHAN_W:0] trial;
    o = p;
    for (int c = 0; c < NUM_COLORS; c++) begin
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
        trial = {o.ch[c].rem, o.ch[c].low[CHAN_W-1]};
        o.ch[c].low = {o.ch[c].low[CHAN_W-2:0], 1'b0};
        if (trial >= {1'b0, o.divisor}) begin
          trial = trial - {1'b0, o.divisor};
          o.ch[c].quo = {o.ch[c].quo[CHAN_W-2:0], 1'b1};
        end else begin
          o.ch[c].quo = {o.ch[c].quo[CHAN_W-2:0], 1'b0};
        end
        o.ch[c].rem = trial[CHAN_W-1:0];
      end
    end
    return o;
  endfunction

endpackage

@@ rtl/core/overbright_color_normalizer.sv @@
// Top level of the overbright color normalizer: shift, overflow test and pipelined rescale.
//
// Usage:
//   Request channel: drive red_in, green_in, blue_in, alpha_in with start high. A request
//   is taken at every rising edge with start high and busy low; busy is always low, so a
//   new pixel may enter in every cycle.
//   Result channel: done is high for exactly one cycle with red_out..alpha_out valid in
//   that cycle. The receiver cannot stall; the pipeline never holds.
//   Pipeline: six register stages (input register, one prepare stage, four divider stages
//   of two quotient bits each); done is the valid bit of the last divider stage.
//   Throughput is one pixel per cycle, set by the fully pipelined divider.
//   Configuration: overbright_shift is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while no request is in flight.
//   Reset (rst, synchronous): clears all valid bits, drops requests in flight, and sets
//   overbright_shift to 1.
// The rescale c*255/max is done on the unshifted channels: the common factor 2^shift
// cancels exactly in the truncating division, so the divider is 16 by 8 bits.
module overbright_color_normalizer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [onc_pkg::CHAN_W-1:0]   red_in,
  input  logic [onc_pkg::CHAN_W-1:0]   green_in,
  input  logic [onc_pkg::CHAN_W-1:0]   blue_in,
  input  logic [onc_pkg::CHAN_W-1:0]   alpha_in,
  output logic                         done,
  output logic [onc_pkg::CHAN_W-1:0]   red_out,
  output logic [onc_pkg::CHAN_W-1:0]   green_out,
  output logic [onc_pkg::CHAN_W-1:0]   blue_out,
  output logic [onc_pkg::CHAN_W-1:0]   alpha_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [onc_pkg::SHIFT_W-1:0]  cfg_data
);

  logic [onc_pkg::SHIFT_W-1:0]                       overbright_shift;

  // Input register.
  logic                                              pix_vld;
  logic [onc_pkg::NUM_COLORS-1:0][onc_pkg::CHAN_W-1:0] pix_color;
  logic [onc_pkg::CHAN_W-1:0]                        pix_alpha;

  // Prepare stage result (combinational) and pipeline registers.
  onc_pkg::pix_t                                     prep;
  logic [onc_pkg::CHAN_W-1:0]                        max_raw;
  logic [onc_pkg::SHIFTED_W-1:0]                     max_shifted;
  logic [onc_pkg::SHIFTED_W-1:0]                     chan_shifted [onc_pkg::NUM_COLORS];
  logic [onc_pkg::NUM_W-1:0]                         chan_num [onc_pkg::NUM_COLORS];

  onc_pkg::pix_t                                     stg     [onc_pkg::DIV_STAGES+1];
  logic                                              stg_vld [onc_pkg::DIV_STAGES+1];

  onc_pkg::pix_t                                     last;

  // The block never refuses a request or a register write.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      overbright_shift <= onc_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      overbright_shift <= cfg_data;
    end
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_vld <= 1'b0;
    end else begin
      pix_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pix_color[onc_pkg::RED]   <= red_in;
    pix_color[onc_pkg::GREEN] <= green_in;
    pix_color[onc_pkg::BLUE]  <= blue_in;
    pix_alpha                 <= alpha_in;
  end

  // Prepare: find the largest channel, test for overflow after the shift, and form
  // the dividend c*255 = (c << 8) - c with its top half preloaded as the remainder.
  always_comb begin
    max_raw = pix_color[onc_pkg::RED];
    if (pix_color[onc_pkg::GREEN] > max_raw) begin
      max_raw = pix_color[onc_pkg::GREEN];
    end
    if (pix_color[onc_pkg::BLUE] > max_raw) begin
      max_raw = pix_color[onc_pkg::BLUE];
    end
    max_shifted = onc_pkg::SHIFTED_W'(max_raw) << overbright_shift;

    prep.divisor = max_raw;
    prep.ovf     = |max_shifted[onc_pkg::SHIFTED_W-1:onc_pkg::CHAN_W];
    prep.alpha   = pix_alpha;
    for (int c = 0; c < onc_pkg::NUM_COLORS; c++) begin
      chan_shifted[c] = onc_pkg::SHIFTED_W'(pix_color[c]) << overbright_shift;
      chan_num[c]     = {pix_color[c], {onc_pkg::CHAN_W{1'b0}}}
                        - onc_pkg::NUM_W'(pix_color[c]);
      prep.plain[c]   = chan_shifted[c][onc_pkg::CHAN_W-1:0];
      prep.ch[c].rem  = chan_num[c][onc_pkg::NUM_W-1:onc_pkg::CHAN_W];
      prep.ch[c].low  = chan_num[c][onc_pkg::CHAN_W-1:0];
      prep.ch[c].quo  = '0;
    end
  end

  // Advance the pipeline: valid bits reset, payload does not.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= onc_pkg::DIV_STAGES; k++) begin
        stg_vld[k] <= 1'b0;
      end
    end else begin
      stg_vld[0] <= pix_vld;
      for (int k = 1; k <= onc_pkg::DIV_STAGES; k++) begin
        stg_vld[k] <= stg_vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    stg[0] <= prep;
    for (int k = 1; k <= onc_pkg::DIV_STAGES; k++) begin
      stg[k] <= onc_pkg::div_stage(stg[k-1]);
    end
  end

  // Pick the rescaled value on overflow, else the plain shifted value.
  assign last      = stg[onc_pkg::DIV_STAGES];
  assign done      = stg_vld[onc_pkg::DIV_STAGES];
  assign red_out   = last.ovf ? last.ch[onc_pkg::RED].quo   : last.plain[onc_pkg::RED];
  assign green_out = last.ovf ? last.ch[onc_pkg::GREEN].quo : last.plain[onc_pkg::GREEN];
  assign blue_out  = last.ovf ? last.ch[onc_pkg::BLUE].quo  : last.plain[onc_pkg::BLUE];
  assign alpha_out = last.alpha;

  // Every result goes back to a matching accepted request.
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result without matching request");

  // On overflow the largest channel must land exactly on full scale.
  a_ovf_full_scale: assert property (@(posedge clk) disable iff (rst)
    (done && last.ovf) |-> (red_out == onc_pkg::CHANNEL_MAX
                            || green_out == onc_pkg::CHANNEL_MAX
                            || blue_out == onc_pkg::CHANNEL_MAX))
    else $error("overflowed pixel not scaled to full scale");

  // The restoring divider keeps every remainder below the divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (done && last.ovf) |-> (last.ch[onc_pkg::RED].rem < last.divisor
                            && last.ch[onc_pkg::GREEN].rem < last.divisor
                            && last.ch[onc_pkg::BLUE].rem < last.divisor))
    else $error("divider remainder out of range");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the overbright color normalizer: directed table plus random pixels.
`timescale 1ns / 100ps

module tb_top;

  // One RGBA pixel. Red sits in the top byte, alpha in the bottom byte.
  typedef struct packed {
    logic [onc_pkg::CHAN_W-1:0] red;
    logic [onc_pkg::CHAN_W-1:0] green;
    logic [onc_pkg::CHAN_W-1:0] blue;
    logic [onc_pkg::CHAN_W-1:0] alpha;
  } pixel_t;

  // A directed row: shift setting, source pixel and, where known, the typed-in answer.
  typedef struct packed {
    logic [onc_pkg::SHIFT_W-1:0] shift;
    pixel_t                      src;
    logic                        fixed;
    pixel_t                      want;
  } pixel_case_t;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 115;

  // Rows with fixed=0 are checked against the predictor only.
  pixel_case_t directed_cases [NUM_DIRECTED] = '{
    // reset value of the shift (1): zero, full white, exact overflow edge, just under it
    {3'd1, 8'd0,   8'd0,   8'd0,   8'h00, 1'b1, 8'd0,   8'd0,   8'd0,   8'h00},
    {3'd1, 8'd255, 8'd255, 8'd255, 8'hFF, 1'b1, 8'd255, 8'd255, 8'd255, 8'hFF},
    {3'd1, 8'd128, 8'd64,  8'd0,   8'h5A, 1'b1, 8'd255, 8'd127, 8'd0,   8'h5A},
    {3'd1, 8'd127, 8'd127, 8'd127, 8'h01, 1'b1, 8'd254, 8'd254, 8'd254, 8'h01},
    {3'd1, 8'd200, 8'd10,  8'd90,  8'h80, 1'b0, 32'h0},
    // shift 0: the pixel passes through untouched
    {3'd0, 8'd255, 8'd0,   8'd128, 8'hA5, 1'b1, 8'd255, 8'd0,   8'd128, 8'hA5},
    {3'd0, 8'd1,   8'd2,   8'd3,   8'hFF, 1'b1, 8'd1,   8'd2,   8'd3,   8'hFF},
    {3'd0, 8'd0,   8'd255, 8'd0,   8'h00, 1'b1, 8'd0,   8'd255, 8'd0,   8'h00},
    // shift 7: largest amount, both sides of the overflow boundary
    {3'd7, 8'd1,   8'd0,   8'd0,   8'h33, 1'b1, 8'd128, 8'd0,   8'd0,   8'h33},
    {3'd7, 8'd255, 8'd1,   8'd0,   8'hA5, 1'b1, 8'd255, 8'd1,   8'd0,   8'hA5},
    {3'd7, 8'd0,   8'd0,   8'd255, 8'h0F, 1'b1, 8'd0,   8'd0,   8'd255, 8'h0F},
    {3'd7, 8'd2,   8'd1,   8'd1,   8'hF0, 1'b1, 8'd255, 8'd127, 8'd127, 8'hF0},
    {3'd7, 8'd37,  8'd200, 8'd91,  8'h3C, 1'b0, 32'h0},
    {3'd7, 8'd1,   8'd1,   8'd1,   8'h55, 1'b1, 8'd128, 8'd128, 8'd128, 8'h55},
    // middle shifts
    {3'd3, 8'd31,  8'd31,  8'd31,  8'h00, 1'b1, 8'd248, 8'd248, 8'd248, 8'h00},
    {3'd3, 8'd32,  8'd16,  8'd8,   8'hC3, 1'b1, 8'd255, 8'd127, 8'd63,  8'hC3},
    {3'd3, 8'd100, 8'd150, 8'd250, 8'h77, 1'b0, 32'h0},
    {3'd4, 8'd15,  8'd0,   8'd15,  8'hE1, 1'b1, 8'd240, 8'd0,   8'd240, 8'hE1},
    {3'd4, 8'd16,  8'd0,   8'd0,   8'h1E, 1'b1, 8'd255, 8'd0,   8'd0,   8'h1E},
    {3'd2, 8'd63,  8'd64,  8'd0,   8'h11, 1'b0, 32'h0},
    {3'd5, 8'd7,   8'd8,   8'd3,   8'hEE, 1'b0, 32'h0},
    {3'd6, 8'd3,   8'd4,   8'd255, 8'h69, 1'b0, 32'h0}
  };

  // Shift order for the random phases; the extremes come first, later phases pick at random.
  logic [onc_pkg::SHIFT_W-1:0] phase_shifts [8] = '{3'd0, 3'd7, 3'd2, 3'd5,
                                                   3'd1, 3'd6, 3'd3, 3'd4};

  string field_names [4] = '{"alpha", "blue", "green", "red"};

  // DUT ports; every input starts at a known value.
  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        start     = 1'b0;
  logic                        busy;
  logic [onc_pkg::CHAN_W-1:0]  red_in    = '0;
  logic [onc_pkg::CHAN_W-1:0]  green_in  = '0;
  logic [onc_pkg::CHAN_W-1:0]  blue_in   = '0;
  logic [onc_pkg::CHAN_W-1:0]  alpha_in  = '0;
  logic                        done;
  logic [onc_pkg::CHAN_W-1:0]  red_out;
  logic [onc_pkg::CHAN_W-1:0]  green_out;
  logic [onc_pkg::CHAN_W-1:0]  blue_out;
  logic [onc_pkg::CHAN_W-1:0]  alpha_out;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [onc_pkg::SHIFT_W-1:0] cfg_data  = '0;

  // Side band that travels with each request: use the typed-in answer instead of the predictor.
  logic   req_fixed = 1'b0;
  pixel_t req_want  = '0;

  // Checker state: shift as the block sees it, and the results still owed.
  logic [onc_pkg::SHIFT_W-1:0] model_shift = onc_pkg::SHIFT_RESET;
  pixel_t                      pending_pixels [$];
  pixel_t                      got_pix;
  pixel_t                      want_pix;
  int                          mismatch_count = 0;
  int                          results_checked = 0;
  int                          requests_sent = 0;
  logic [7:0]                  shifts_seen = 8'd1 << onc_pkg::SHIFT_RESET;

  // Driver state: shift last written, and the burst pattern of the sender.
  logic [onc_pkg::SHIFT_W-1:0] active_shift = onc_pkg::SHIFT_RESET;
  int                          burst_left = 0;

  overbright_color_normalizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .done      (done),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shift the color channels, then rescale all three by 255/peak if the peak overflows.
  function automatic pixel_t normalize_pixel(input logic [onc_pkg::SHIFT_W-1:0] shift,
                                             input pixel_t src);
    int unsigned sr, sg, sb, peak;
    pixel_t      res;
    sr   = 32'(src.red) << shift;
    sg   = 32'(src.green) << shift;
    sb   = 32'(src.blue) << shift;
    peak = (sr > sg) ? sr : sg;
    peak = (peak > sb) ? peak : sb;
    if (peak > 32'(onc_pkg::CHANNEL_MAX)) begin
      sr = sr * 32'(onc_pkg::CHANNEL_MAX) / peak;
      sg = sg * 32'(onc_pkg::CHANNEL_MAX) / peak;
      sb = sb * 32'(onc_pkg::CHANNEL_MAX) / peak;
    end
    res.red   = onc_pkg::CHAN_W'(sr);
    res.green = onc_pkg::CHAN_W'(sg);
    res.blue  = onc_pkg::CHAN_W'(sb);
    res.alpha = src.alpha;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Checker: track register writes, queue a prediction per accepted request, compare results.
  // All of it samples at the rising edge, so it sees the values from before the edge.
  always @(posedge clk) begin
    if (rst) begin
      model_shift = onc_pkg::SHIFT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        model_shift = cfg_data;
        shifts_seen[cfg_data] = 1'b1;
      end
      if (start && !busy) begin
        if (req_fixed) begin
          pending_pixels.push_back(req_want);
        end else begin
          pending_pixels.push_back(normalize_pixel(model_shift,
                                                   {red_in, green_in, blue_in, alpha_in}));
        end
      end
      if (done) begin
        got_pix = {red_out, green_out, blue_out, alpha_out};
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding", got_pix));
        end else begin
          want_pix = pending_pixels.pop_front();
          results_checked++;
          for (int f = 3; f >= 0; f--) begin
            if (got_pix[8*f +: 8] !== want_pix[8*f +: 8]) begin
              report_mismatch($sformatf("%s_out got %0d expected %0d", field_names[f],
                                        got_pix[8*f +: 8], want_pix[8*f +: 8]));
            end
          end
        end
      end
    end
  end

  // Hold requests off and wait until every owed result has come out.
  // The first edge lets the checker queue the last accepted request before the count is read.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Write the overbright shift; only call with the pipeline drained.
  task automatic write_shift(input logic [onc_pkg::SHIFT_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    active_shift  = value;
  endtask

  // Issue one request. Open a new burst after a random gap when the current one runs out;
  // some bursts are long so stretches with no gaps show up too.
  task automatic send_pixel(input pixel_t src, input logic fixed, input pixel_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start     <= 1'b1;
    red_in    <= src.red;
    green_in  <= src.green;
    blue_in   <= src.blue;
    alpha_in  <= src.alpha;
    req_fixed <= fixed;
    req_want  <= want;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // Stimulus: directed table, then random phases each at its own shift setting.
  initial begin
    pixel_t                      src;
    logic [onc_pkg::SHIFT_W-1:0] next_shift;
    int                          hot;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; drain and rewrite the shift whenever a row asks for a new one.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_cases[i].shift != active_shift) begin
        drain_pipeline();
        write_shift(directed_cases[i].shift);
      end
      send_pixel(directed_cases[i].src, directed_cases[i].fixed, directed_cases[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      next_shift = (p < 8) ? phase_shifts[p] : onc_pkg::SHIFT_W'($urandom_range(0, 7));
      drain_pipeline();
      write_shift(next_shift);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        src = $urandom();
        case ($urandom_range(0, 4))
          // small channels: always stay under the overflow line at this shift
          1: begin
            src.red   = src.red >> active_shift;
            src.green = src.green >> active_shift;
            src.blue  = src.blue >> active_shift;
          end
          // one channel at full scale
          2: begin
            hot = $urandom_range(0, 2);
            if (hot == onc_pkg::RED) src.red = onc_pkg::CHANNEL_MAX;
            else if (hot == onc_pkg::GREEN) src.green = onc_pkg::CHANNEL_MAX;
            else src.blue = onc_pkg::CHANNEL_MAX;
          end
          // gray pixel: all channels equal
          3: begin
            src.green = src.red;
            src.blue  = src.red;
          end
          // channels picked from the corners of the range
          4: begin
            src.red   = ($urandom_range(0, 1) != 0)
                        ? onc_pkg::CHANNEL_MAX - onc_pkg::CHAN_W'(src.red[0])
                        : onc_pkg::CHAN_W'(src.red[0]);
            src.green = ($urandom_range(0, 1) != 0)
                        ? onc_pkg::CHANNEL_MAX - onc_pkg::CHAN_W'(src.green[0])
                        : onc_pkg::CHAN_W'(src.green[0]);
            src.blue  = ($urandom_range(0, 1) != 0)
                        ? onc_pkg::CHANNEL_MAX - onc_pkg::CHAN_W'(src.blue[0])
                        : onc_pkg::CHAN_W'(src.blue[0]);
          end
          default: ;
        endcase
        // now and then let the pipeline run dry in the middle of a phase
        if ($urandom_range(0, 99) == 0) drain_pipeline();
        send_pixel(src, 1'b0, '0);
      end
    end

    // Drop start, collect the tail, then give stray results time to show up.
    drain_pipeline();
    repeat (12) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
    end

    $display("Sent %0d pixels, checked %0d results, %0d mismatches.",
             requests_sent, results_checked, mismatch_count);
    $display("Shift settings exercised (bit mask): %b", shifts_seen);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
